// File: rtl/bmftl_pkg.sv
// Shared widths, operation codes and status codes of the flash translation controller.
package bmftl_pkg;

  localparam int CMD_W  = 1;
  localparam int LSN_W  = 16;
  localparam int SLOT_W = 8;
  localparam int OP_W   = 3;
  localparam int PAGE_W = 10;
  localparam int BLKF_W = 5;
  localparam int STAT_W = 3;

  localparam logic [CMD_W-1:0] CMD_READ  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 1'b1;

  localparam logic [OP_W-1:0] OP_READ  = 3'd0;
  localparam logic [OP_W-1:0] OP_PROG  = 3'd1;
  localparam logic [OP_W-1:0] OP_COPY  = 3'd2;
  localparam logic [OP_W-1:0] OP_ERASE = 3'd3;
  localparam logic [OP_W-1:0] OP_ERR   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_INVALID   = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNMAPPED  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_FREE   = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [PAGE_W-1:0] src_page;
    logic [PAGE_W-1:0] dst_page;
    logic [BLKF_W-1:0] erase_block;
    logic [SLOT_W-1:0] slot;
    logic [STAT_W-1:0] status;
    logic              last;
  } result_t;

endpackage

// File: rtl/bmftl_if.sv
// Request and result channel interfaces of the flash translation controller.
interface bmftl_in_if import bmftl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [LSN_W-1:0]  lsn;
  logic [SLOT_W-1:0] buffer_slot;

  modport source (output valid, cmd, lsn, buffer_slot, input ready);
  modport sink   (input valid, cmd, lsn, buffer_slot, output ready);
endinterface

interface bmftl_out_if import bmftl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [PAGE_W-1:0] src_page;
  logic [PAGE_W-1:0] dst_page;
  logic [BLKF_W-1:0] erase_block;
  logic [SLOT_W-1:0] slot;
  logic [STAT_W-1:0] status;
  logic              last;

  modport source (output valid, op, src_page, dst_page, erase_block, slot, status, last,
                  input ready);
  modport sink   (input valid, op, src_page, dst_page, erase_block, slot, status, last,
                  output ready);
endinterface

// File: rtl/bmftl_div.sv
// Reciprocal-multiply divider that splits a sector number into block number and offset.
module bmftl_div import bmftl_pkg::*; #(
  parameter int DIVISOR = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [LSN_W-1:0]             dividend,
  output logic                         done,
  output logic [LSN_W-1:0]             quo,
  output logic [$clog2(DIVISOR)-1:0]   rem
);

  localparam int     RW    = $clog2(DIVISOR);
  localparam int     SH    = LSN_W + RW;
  localparam int     MW    = LSN_W + 1;
  localparam int     PW    = LSN_W + MW;
  // ceil(2^SH / DIVISOR) gives the exact quotient for every LSN_W-bit dividend
  localparam longint RECIP = ((longint'(1) << SH) + longint'(DIVISOR) - 1) /
                             longint'(DIVISOR);
  localparam logic [MW-1:0] RECIP_C = MW'(RECIP);

  logic             done_r;
  logic [LSN_W-1:0] num_r;
  logic [LSN_W-1:0] quo_r;
  logic [PW-1:0]    prod;
  logic [LSN_W-1:0] back;
  logic [LSN_W-1:0] diff;

  assign prod = PW'(dividend) * PW'(RECIP_C);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
  end

  // hold the dividend and its quotient for the offset subtract
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      quo_r <= LSN_W'(prod >> SH);
    end
  end

  assign back = quo_r * LSN_W'(DIVISOR);
  assign diff = num_r - back;

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = diff[RW-1:0];

endmodule

// File: rtl/block_mapped_ftl_with_log_append.sv
// Top level of the block-mapped flash translation controller with in-block logging.
//
// in_ch carries one request word: cmd (read or write), lsn and buffer_slot.
// out_ch carries the flash operation words the request causes: one read, one
// program, or on a write into a full block a run of copies, a program and an
// erase; errors come as one word with op error. The word that ends a request
// has last set.
// Requests are taken one at a time and pass through accept, the divider that
// splits lsn into block and offset, the range check and the map read, where
// an append emits its program word; a first write adds a pop and a program
// step. A read then scans page tags one per cycle from the newest page down.
// A collection walks every tag of the old block, pops a block, then walks the
// offsets again, one per cycle, with an extra step for each copy, which
// waits while the receiver stalls.
// After reset a clearing pass writes the map entries in turn and marks every
// logical block unmapped; in_ch.ready stays low during it. The free stack
// starts full with block 0 on top.
// Results sit in an output register; while the receiver stalls, the block
// holds its current step and resumes when the word is taken.
module block_mapped_ftl_with_log_append import bmftl_pkg::*; #(
  parameter int PAGES_PER_BLOCK_P = 32,
  parameter int PHYS_BLOCKS       = 32,
  parameter int DATA_BLOCKS       = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  bmftl_in_if.sink    in_ch,
  bmftl_out_if.source out_ch
);

  localparam int P      = PAGES_PER_BLOCK_P;
  localparam int OFF_W  = $clog2(P);
  localparam int IDX_W  = OFF_W + 1;
  localparam int BLK_W  = $clog2(PHYS_BLOCKS);
  localparam int LBN_W  = (DATA_BLOCKS > 1) ? $clog2(DATA_BLOCKS) : 1;
  localparam int PG_W   = $clog2(PHYS_BLOCKS * P);
  localparam int FC_W   = $clog2(PHYS_BLOCKS + 1);
  localparam logic [LSN_W:0] LSN_LIMIT = (LSN_W + 1)'(DATA_BLOCKS * P);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_CLR    = 4'd0;
  localparam logic [ST_W-1:0] S_IDLE   = 4'd1;
  localparam logic [ST_W-1:0] S_DIV    = 4'd2;
  localparam logic [ST_W-1:0] S_CHK    = 4'd3;
  localparam logic [ST_W-1:0] S_MAP    = 4'd4;
  localparam logic [ST_W-1:0] S_RSCAN  = 4'd5;
  localparam logic [ST_W-1:0] S_POP    = 4'd6;
  localparam logic [ST_W-1:0] S_WNEW   = 4'd7;
  localparam logic [ST_W-1:0] S_GSCAN  = 4'd8;
  localparam logic [ST_W-1:0] S_GPOP   = 4'd9;
  localparam logic [ST_W-1:0] S_CRD    = 4'd10;
  localparam logic [ST_W-1:0] S_CEM    = 4'd11;
  localparam logic [ST_W-1:0] S_CPROG  = 4'd12;
  localparam logic [ST_W-1:0] S_CERASE = 4'd13;

  typedef struct packed {
    logic             v;
    logic [BLK_W-1:0] blk;
    logic [OFF_W-1:0] lo;
  } map_ent_t;

  function automatic logic [PG_W-1:0] pg_addr(input logic [BLK_W-1:0] b,
                                              input logic [OFF_W-1:0] o);
    return PG_W'(b) * PG_W'(P) + PG_W'(o);
  endfunction

  // control and payload registers
  logic [ST_W-1:0]   state_r, state_nxt;
  logic [LBN_W-1:0]  clr_r, clr_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [LSN_W-1:0]  lsn_r, lsn_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [LBN_W-1:0]  lbn_r, lbn_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [BLK_W-1:0]  blk_r, blk_nxt;
  logic [BLK_W-1:0]  nb_r, nb_nxt;
  logic [OFF_W-1:0]  p_r, p_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [OFF_W-1:0]  n_r, n_nxt;
  logic [FC_W-1:0]   fc_r, fc_nxt;
  logic [FC_W-1:0]   lw_r, lw_nxt;
  logic              fresh_r, fresh_nxt;
  logic [P-1:0]      nv_r, nv_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_r, out_nxt;

  // memories
  map_ent_t         map_mem [DATA_BLOCKS];
  logic [OFF_W-1:0] tag_mem [PHYS_BLOCKS * P];
  logic [BLK_W-1:0] stk_mem [PHYS_BLOCKS];
  logic [OFF_W-1:0] nw_mem  [P];

  map_ent_t         map_q, map_wdata;
  logic [LBN_W-1:0] map_raddr, map_waddr;
  logic             map_we;
  logic [OFF_W-1:0] tag_q, tag_wdata;
  logic [PG_W-1:0]  tag_raddr, tag_waddr;
  logic             tag_we;
  logic [BLK_W-1:0] stk_q, stk_wdata, stk_raddr, stk_waddr;
  logic             stk_we;
  logic [OFF_W-1:0] nw_q, nw_wdata, nw_raddr, nw_waddr;
  logic             nw_we;

  logic              div_start, div_done;
  logic [LSN_W-1:0]  div_quo;
  logic [OFF_W-1:0]  div_rem;
  logic              in_ready;
  logic              out_free;
  logic              emit;
  result_t           res;
  logic [BLK_W-1:0]  popped;

  bmftl_div #(.DIVISOR(P)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_ch.lsn),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign in_ready  = state_r == S_IDLE;
  assign div_start = in_ready && in_ch.valid;
  assign out_free  = !out_valid_r || out_ch.ready;
  // a stack slot below the lowest level ever reached still holds its reset value
  assign popped    = fresh_r ? BLK_W'(PHYS_BLOCKS - 1) - fc_r[BLK_W-1:0] : stk_q;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cmd_nxt   = cmd_r;
    lsn_nxt   = lsn_r;
    slot_nxt  = slot_r;
    lbn_nxt   = lbn_r;
    off_nxt   = off_r;
    blk_nxt   = blk_r;
    nb_nxt    = nb_r;
    p_nxt     = p_r;
    i_nxt     = i_r;
    n_nxt     = n_r;
    fc_nxt    = fc_r;
    lw_nxt    = lw_r;
    fresh_nxt = fresh_r;
    nv_nxt    = nv_r;

    map_raddr = lbn_r;
    map_we    = 1'b0;
    map_waddr = lbn_r;
    map_wdata = '0;
    tag_raddr = pg_addr(blk_r, p_r);
    tag_we    = 1'b0;
    tag_waddr = '0;
    tag_wdata = '0;
    stk_raddr = '0;
    stk_we    = 1'b0;
    stk_waddr = fc_r[BLK_W-1:0];
    stk_wdata = blk_r;
    nw_raddr  = i_r[OFF_W-1:0];
    nw_we     = 1'b0;
    nw_waddr  = tag_q;
    nw_wdata  = '0;

    emit = 1'b0;
    res  = '0;

    unique case (state_r)
      S_CLR: begin
        // mark every logical block unmapped
        map_we    = 1'b1;
        map_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LBN_W'(DATA_BLOCKS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.cmd;
          lsn_nxt   = in_ch.lsn;
          slot_nxt  = in_ch.buffer_slot;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          lbn_nxt   = div_quo[LBN_W-1:0];
          off_nxt   = div_rem;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if ({1'b0, lsn_r} >= LSN_LIMIT) begin
          if (out_free) begin
            emit       = 1'b1;
            res.op     = OP_ERR;
            res.status = ST_INVALID;
            res.last   = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        if (cmd_r == CMD_READ) begin
          if (!map_q.v) begin
            if (out_free) begin
              emit       = 1'b1;
              res.op     = OP_ERR;
              res.status = ST_UNMAPPED;
              res.last   = 1'b1;
              state_nxt  = S_IDLE;
            end
          end else begin
            blk_nxt   = map_q.blk;
            p_nxt     = map_q.lo;
            tag_raddr = pg_addr(map_q.blk, map_q.lo);
            state_nxt = S_RSCAN;
          end
        end else if (!map_q.v) begin
          if (fc_r == '0) begin
            if (out_free) begin
              emit       = 1'b1;
              res.op     = OP_ERR;
              res.status = ST_NO_FREE;
              res.last   = 1'b1;
              state_nxt  = S_IDLE;
            end
          end else begin
            stk_raddr = fc_r[BLK_W-1:0] - 1'b1;
            fresh_nxt = fc_r == lw_r;
            fc_nxt    = fc_r - 1'b1;
            if (fc_r == lw_r) begin
              lw_nxt = fc_r - 1'b1;
            end
            state_nxt = S_POP;
          end
        end else if (map_q.lo < OFF_W'(P - 1)) begin
          // append at the next page of the mapped block
          if (out_free) begin
            tag_we        = 1'b1;
            tag_waddr     = pg_addr(map_q.blk, map_q.lo + 1'b1);
            tag_wdata     = off_r;
            map_we        = 1'b1;
            map_wdata.v   = 1'b1;
            map_wdata.blk = map_q.blk;
            map_wdata.lo  = map_q.lo + 1'b1;
            emit          = 1'b1;
            res.op        = OP_PROG;
            res.dst_page  = PAGE_W'(pg_addr(map_q.blk, map_q.lo + 1'b1));
            res.slot      = slot_r;
            res.last      = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          // block full: collect it
          blk_nxt   = map_q.blk;
          nv_nxt    = '0;
          i_nxt     = '0;
          state_nxt = S_GSCAN;
        end
      end
      S_RSCAN: begin
        if (tag_q == off_r) begin
          if (out_free) begin
            emit         = 1'b1;
            res.op       = OP_READ;
            res.src_page = PAGE_W'(pg_addr(blk_r, p_r));
            res.slot     = slot_r;
            res.last     = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (p_r == '0) begin
          if (out_free) begin
            emit       = 1'b1;
            res.op     = OP_ERR;
            res.status = ST_NOT_FOUND;
            res.last   = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          p_nxt     = p_r - 1'b1;
          tag_raddr = pg_addr(blk_r, p_r - 1'b1);
        end
      end
      S_POP: begin
        nb_nxt    = popped;
        state_nxt = S_WNEW;
      end
      S_WNEW: begin
        if (out_free) begin
          map_we        = 1'b1;
          map_wdata.v   = 1'b1;
          map_wdata.blk = nb_r;
          map_wdata.lo  = '0;
          tag_we        = 1'b1;
          tag_waddr     = pg_addr(nb_r, '0);
          tag_wdata     = off_r;
          emit          = 1'b1;
          res.op        = OP_PROG;
          res.dst_page  = PAGE_W'(pg_addr(nb_r, '0));
          res.slot      = slot_r;
          res.last      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_GSCAN: begin
        // tag_q holds the tag of page i-1; later pages overwrite earlier ones
        if (i_r != '0) begin
          if (IDX_W'(tag_q) < IDX_W'(P)) begin
            nw_we          = 1'b1;
            nw_waddr       = tag_q;
            nw_wdata       = OFF_W'(i_r - 1'b1);
            nv_nxt[tag_q]  = 1'b1;
          end
        end
        if (i_r != IDX_W'(P)) begin
          tag_raddr = pg_addr(blk_r, i_r[OFF_W-1:0]);
          i_nxt     = i_r + 1'b1;
        end else if (fc_r == '0) begin
          if (out_free) begin
            nw_we      = 1'b0;
            emit       = 1'b1;
            res.op     = OP_ERR;
            res.status = ST_NO_FREE;
            res.last   = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            // hold: the last tag is not written; the error word is retried
            nv_nxt = nv_r;
            nw_we  = 1'b0;
            i_nxt  = i_r;
          end
        end else begin
          stk_raddr = fc_r[BLK_W-1:0] - 1'b1;
          fresh_nxt = fc_r == lw_r;
          fc_nxt    = fc_r - 1'b1;
          if (fc_r == lw_r) begin
            lw_nxt = fc_r - 1'b1;
          end
          state_nxt = S_GPOP;
        end
      end
      S_GPOP: begin
        nb_nxt    = popped;
        i_nxt     = '0;
        n_nxt     = '0;
        state_nxt = S_CRD;
      end
      S_CRD: begin
        if (i_r == IDX_W'(P)) begin
          state_nxt = S_CPROG;
        end else if (!nv_r[i_r[OFF_W-1:0]] || i_r[OFF_W-1:0] == off_r) begin
          i_nxt = i_r + 1'b1;
        end else begin
          state_nxt = S_CEM;
        end
      end
      S_CEM: begin
        // the newest page of offset i carries tag i
        if (out_free) begin
          tag_we       = 1'b1;
          tag_waddr    = pg_addr(nb_r, n_r);
          tag_wdata    = i_r[OFF_W-1:0];
          emit         = 1'b1;
          res.op       = OP_COPY;
          res.src_page = PAGE_W'(pg_addr(blk_r, nw_q));
          res.dst_page = PAGE_W'(pg_addr(nb_r, n_r));
          n_nxt        = n_r + 1'b1;
          i_nxt        = i_r + 1'b1;
          state_nxt    = S_CRD;
        end
      end
      S_CPROG: begin
        if (out_free) begin
          tag_we       = 1'b1;
          tag_waddr    = pg_addr(nb_r, n_r);
          tag_wdata    = off_r;
          emit         = 1'b1;
          res.op       = OP_PROG;
          res.dst_page = PAGE_W'(pg_addr(nb_r, n_r));
          res.slot     = slot_r;
          state_nxt    = S_CERASE;
        end
      end
      S_CERASE: begin
        if (out_free) begin
          emit            = 1'b1;
          res.op          = OP_ERASE;
          res.erase_block = BLKF_W'(blk_r);
          res.last        = 1'b1;
          map_we          = 1'b1;
          map_wdata.v     = 1'b1;
          map_wdata.blk   = nb_r;
          map_wdata.lo    = n_r;
          // push the old block; drop it if the stack is somehow full
          if (fc_r < FC_W'(PHYS_BLOCKS)) begin
            stk_we = 1'b1;
            fc_nxt = fc_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      fc_r        <= FC_W'(PHYS_BLOCKS);
      lw_r        <= FC_W'(PHYS_BLOCKS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      fc_r        <= fc_nxt;
      lw_r        <= lw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    lsn_r   <= lsn_nxt;
    slot_r  <= slot_nxt;
    lbn_r   <= lbn_nxt;
    off_r   <= off_nxt;
    blk_r   <= blk_nxt;
    nb_r    <= nb_nxt;
    p_r     <= p_nxt;
    i_r     <= i_nxt;
    n_r     <= n_nxt;
    fresh_r <= fresh_nxt;
    nv_r    <= nv_nxt;
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_q <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    tag_q <= tag_mem[tag_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (nw_we) begin
      nw_mem[nw_waddr] <= nw_wdata;
    end
    nw_q <= nw_mem[nw_raddr];
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.op          = out_r.op;
  assign out_ch.src_page    = out_r.src_page;
  assign out_ch.dst_page    = out_r.dst_page;
  assign out_ch.erase_block = out_r.erase_block;
  assign out_ch.slot        = out_r.slot;
  assign out_ch.status      = out_r.status;
  assign out_ch.last        = out_r.last;

  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= FC_W'(PHYS_BLOCKS))
    else $error("free count above block count");

  a_low_mark: assert property (@(posedge clk) disable iff (!rst_n)
    lw_r <= fc_r)
    else $error("stack low mark above free count");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.op == OP_ERR |-> out_r.last && out_r.status != ST_OK)
    else $error("error word without status or last");

  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.op != OP_ERR |-> out_r.status == ST_OK)
    else $error("flash operation word carries an error status");

  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

endmodule

// File: sim/testbench.sv
// Testbench for the block-mapped flash translation controller: scoreboard, drivers, checks.
`timescale 1ns / 100ps

module testbench;
  import bmftl_pkg::*;

  localparam int PPB        = 32;
  localparam int PBLOCKS    = 32;
  localparam int DBLOCKS    = 31;
  localparam int N_RANDOM   = 268;
  localparam int CYCLE_CAP  = 1500000;
  localparam int DRAIN_WAIT = 150;

  // Translation state kept alongside the block; computes the flash words
  // each request should produce and checks them in order.
  class ftl_scoreboard;
    bit         blk_mapped [DBLOCKS];
    logic [4:0] blk_phys   [DBLOCKS];
    logic [4:0] blk_top    [DBLOCKS];
    logic [4:0] tag_of     [PBLOCKS*PPB];
    logic [4:0] free_blk   [PBLOCKS];
    int         free_cnt;
    result_t    pending_words[$];
    int         errors;
    int         words_ok;
    int         collections;

    function new();
      for (int i = 0; i < DBLOCKS; i++) blk_mapped[i] = 0;
      for (int i = 0; i < PBLOCKS; i++) free_blk[i] = 5'(PBLOCKS - 1 - i);
      free_cnt    = PBLOCKS;
      errors      = 0;
      words_ok    = 0;
      collections = 0;
    endfunction

    function void push_word(logic [OP_W-1:0] op, int src, int dst, int blk,
                            logic [SLOT_W-1:0] slot, logic [STAT_W-1:0] st, bit fin);
      result_t w;
      w.op          = op;
      w.src_page    = PAGE_W'(src);
      w.dst_page    = PAGE_W'(dst);
      w.erase_block = BLKF_W'(blk);
      w.slot        = slot;
      w.status      = st;
      w.last        = fin;
      pending_words.push_back(w);
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [LSN_W-1:0] lsn,
                               logic [SLOT_W-1:0] slot);
      int lbn, off, blk, nb, n;
      int newest[PPB];
      bit seen[PPB];
      if (lsn >= DBLOCKS * PPB) begin
        push_word(OP_ERR, 0, 0, 0, '0, ST_INVALID, 1);
        return;
      end
      lbn = lsn / PPB;
      off = lsn % PPB;
      if (cmd == CMD_READ) begin
        if (!blk_mapped[lbn]) begin
          push_word(OP_ERR, 0, 0, 0, '0, ST_UNMAPPED, 1);
          return;
        end
        blk = blk_phys[lbn];
        for (int p = blk_top[lbn]; p >= 0; p--) begin
          if (tag_of[blk*PPB + p] == off) begin
            push_word(OP_READ, blk*PPB + p, 0, 0, slot, ST_OK, 1);
            return;
          end
        end
        push_word(OP_ERR, 0, 0, 0, '0, ST_NOT_FOUND, 1);
        return;
      end
      if (!blk_mapped[lbn]) begin
        if (free_cnt == 0) begin
          push_word(OP_ERR, 0, 0, 0, '0, ST_NO_FREE, 1);
          return;
        end
        free_cnt--;
        blk = free_blk[free_cnt];
        blk_mapped[lbn] = 1;
        blk_phys[lbn]   = 5'(blk);
        blk_top[lbn]    = 0;
        tag_of[blk*PPB] = 5'(off);
        push_word(OP_PROG, 0, blk*PPB, 0, slot, ST_OK, 1);
        return;
      end
      blk = blk_phys[lbn];
      if (blk_top[lbn] < PPB - 1) begin
        n = blk_top[lbn] + 1;
        tag_of[blk*PPB + n] = 5'(off);
        blk_top[lbn] = 5'(n);
        push_word(OP_PROG, 0, blk*PPB + n, 0, slot, ST_OK, 1);
        return;
      end
      // Full block: find newest page per offset, then relocate.
      for (int i = 0; i < PPB; i++) seen[i] = 0;
      for (int i = 0; i < PPB; i++) begin
        newest[tag_of[blk*PPB + i]] = i;
        seen[tag_of[blk*PPB + i]]   = 1;
      end
      if (free_cnt == 0) begin
        push_word(OP_ERR, 0, 0, 0, '0, ST_NO_FREE, 1);
        return;
      end
      collections++;
      free_cnt--;
      nb = free_blk[free_cnt];
      n  = 0;
      for (int i = 0; i < PPB; i++) begin
        if (seen[i] && i != off) begin
          tag_of[nb*PPB + n] = tag_of[blk*PPB + newest[i]];
          push_word(OP_COPY, blk*PPB + newest[i], nb*PPB + n, 0, '0, ST_OK, 0);
          n++;
        end
      end
      tag_of[nb*PPB + n] = 5'(off);
      push_word(OP_PROG, 0, nb*PPB + n, 0, slot, ST_OK, 0);
      push_word(OP_ERASE, 0, 0, blk, '0, ST_OK, 1);
      if (free_cnt < PBLOCKS) begin
        free_blk[free_cnt] = 5'(blk);
        free_cnt++;
      end
      blk_phys[lbn] = 5'(nb);
      blk_top[lbn]  = 5'(n);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_word(result_t got);
      result_t want;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word op=%0d", got.op));
        return;
      end
      want = pending_words.pop_front();
      if (got !== want)
        report($sformatf("got op=%0d src=%0d dst=%0d blk=%0d slot=%0d st=%0d last=%0d, want op=%0d src=%0d dst=%0d blk=%0d slot=%0d st=%0d last=%0d",
               got.op, got.src_page, got.dst_page, got.erase_block, got.slot, got.status,
               got.last, want.op, want.src_page, want.dst_page, want.erase_block,
               want.slot, want.status, want.last));
      else
        words_ok++;
    endtask
  endclass

  logic clk;
  logic rst_n;

  bmftl_in_if  in_ch ();
  bmftl_out_if out_ch ();

  block_mapped_ftl_with_log_append u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  ftl_scoreboard sb = new();

  int  accepted_reqs = 0;
  int  cycles = 0;
  bit  hold_out = 0;      // long receiver hold-off, driven by its own process
  int  stall_left = 0;
  int  gap;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Cap the run; a hung block ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Note accepted requests and check result words at the edge that takes them.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_request(in_ch.cmd, in_ch.lsn, in_ch.buffer_slot);
      accepted_reqs <= accepted_reqs + 1;
    end
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_word('{op: out_ch.op, src_page: out_ch.src_page, dst_page: out_ch.dst_page,
                      erase_block: out_ch.erase_block, slot: out_ch.slot,
                      status: out_ch.status, last: out_ch.last});
  end

  // Receiver: draw a stall after each word; every third stretch of
  // 40 requests runs with no stalls.
  always @(posedge clk) begin
    if (!rst_n || hold_out) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      gap = ((accepted_reqs / 40) % 3 == 1) ? 0 : $urandom_range(0, 6);
      out_ch.ready <= (gap == 0);
      stall_left   <= gap;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= (stall_left == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Hold off the receiver for a long stretch mid-run so the block backs up.
  initial begin
    wait (accepted_reqs >= 120);
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (400) @(posedge clk);
    hold_out <= 1'b0;
  end

  // Offer one request word and hold it until taken, then idle a random gap.
  task send_req(logic [CMD_W-1:0] cmd, logic [LSN_W-1:0] lsn, logic [SLOT_W-1:0] slot);
    int idle;
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.lsn         <= lsn;
    in_ch.buffer_slot <= slot;
    do @(posedge clk); while (!in_ch.ready);
    idle = ((accepted_reqs / 40) % 3 == 2) ? 0 : $urandom_range(0, 6);
    if (idle > 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  // Mostly hit two busy logical blocks with few offsets so they fill and
  // get collected; the rest is spread traffic and raw noise.
  task send_random;
    int pick, lbn, off;
    logic [LSN_W-1:0] lsn;
    logic [CMD_W-1:0] cmd;
    pick = $urandom_range(0, 99);
    cmd  = ($urandom_range(0, 99) < 65) ? CMD_WRITE : CMD_READ;
    if (pick < 80) begin
      lbn = (pick < 65) ? 2 + $urandom_range(0, 1) : $urandom_range(0, DBLOCKS - 1);
      off = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 5) : $urandom_range(0, PPB - 1);
      lsn = LSN_W'(lbn * PPB + off);
    end else begin
      lsn = LSN_W'($urandom_range(0, 16'hFFFF));
    end
    send_req(cmd, lsn, SLOT_W'($urandom_range(0, 255)));
  endtask

  initial begin
    int waited;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_READ;
    in_ch.lsn         = '0;
    in_ch.buffer_slot = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: errors, first write, hits and misses, range edges.
    send_req(CMD_READ,  16'd0,     8'd0);    // unmapped
    send_req(CMD_READ,  16'd992,   8'd7);    // first invalid sector
    send_req(CMD_WRITE, 16'hFFFF,  8'hFF);   // invalid write
    send_req(CMD_WRITE, 16'd5,     8'd0);
    send_req(CMD_READ,  16'd5,     8'hFF);
    send_req(CMD_READ,  16'd6,     8'd1);    // no matching page
    send_req(CMD_WRITE, 16'd991,   8'hAA);   // last valid sector
    send_req(CMD_READ,  16'd991,   8'h55);
    // Fill logical block 0 and force a collection.
    for (int i = 0; i < 32; i++)
      send_req(CMD_WRITE, LSN_W'(i % 3), 8'(i));
    send_req(CMD_READ,  16'd1,     8'd9);
    send_req(CMD_READ,  16'd5,     8'd3);    // older offset copied forward

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 200) begin
        // Pause until the block has drained everything.
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending_words.size() != 0);
      end
      send_random();
    end
    in_ch.valid <= 1'b0;

    waited = 0;
    while (sb.pending_words.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.pending_words.size() != 0)
      sb.report($sformatf("%0d words never arrived", sb.pending_words.size()));

    $display("covered %0d requests, %0d matching flash words, %0d block collections",
             accepted_reqs, sb.words_ok, sb.collections);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
